@@ rtl/ellipse_arc_vertex_generator_macros.svh @@
// assertion macros shared by the arc vertex generator rtl
// expects clk and rst in scope at the point of use
`ifndef ELLIPSE_ARC_VERTEX_GENERATOR_MACROS_SVH
`define ELLIPSE_ARC_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication, idle during reset
`define EAVG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define EAVG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/eavg_pkg.sv @@
// shared types, constants and the arctangent table of the arc generator
// no dependencies
package eavg_pkg;

  localparam int MAX_POINTS_DEF = 62;
  localparam int CORDIC_STEPS   = 16;
  localparam int DIV_STEPS      = 22;   // magnitude bits of delta * index
  localparam int ACC_W          = 23;   // signed delta * index
  localparam int CW             = 34;   // rotation x / y width, q2.30 plus headroom
  localparam int ZW             = 33;   // residual angle, 2^32 per turn
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef logic signed [15:0] coord_t;

  function automatic logic [31:0] atan_entry(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0:    v = 32'd536870912;
      4'd1:    v = 32'd316933406;
      4'd2:    v = 32'd167458907;
      4'd3:    v = 32'd85004756;
      4'd4:    v = 32'd42667331;
      4'd5:    v = 32'd21354465;
      4'd6:    v = 32'd10679838;
      4'd7:    v = 32'd5340245;
      4'd8:    v = 32'd2670163;
      4'd9:    v = 32'd1335087;
      4'd10:   v = 32'd667544;
      4'd11:   v = 32'd333772;
      4'd12:   v = 32'd166886;
      4'd13:   v = 32'd83443;
      4'd14:   v = 32'd41721;
      4'd15:   v = 32'd20860;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/eavg_divider.sv @@
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// depends on eavg_pkg
module eavg_divider
  import eavg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] dividend,
  input  logic [5:0]              divisor,
  output logic                    done,
  output logic [15:0]             quotient
);

  logic [DIV_STEPS-1:0] q;
  logic [5:0]           rem;
  logic [5:0]           dsr;
  logic [4:0]           cnt;
  logic                 run;
  logic                 neg;
  logic [6:0]           trial;
  logic                 ge;
  logic [ACC_W-1:0]     mag;
  logic [15:0]          q_low;

  assign mag   = dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem, q[DIV_STEPS-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign q_low = q[15:0];
  assign quotient = neg ? (~q_low + 16'd1) : q_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= mag[DIV_STEPS-1:0];
      rem <= '0;
      dsr <= divisor;
      neg <= dividend[ACC_W-1];
    end else if (run) begin
      rem <= ge ? 6'(trial - {1'b0, dsr}) : trial[5:0];
      q   <= {q[DIV_STEPS-2:0], ge};
    end
  end

endmodule

@@ rtl/eavg_cordic.sv @@
// iterative rotation unit, one micro-rotation per cycle, gives q1.15 cos and sin
// depends on eavg_pkg
module eavg_cordic
  import eavg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] angle,
  output logic        done,
  output coord_t      cos_q15,
  output coord_t      sin_q15
);

  logic signed [CW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic                 flip;
  logic [3:0]           cnt;
  logic                 run;
  logic signed [CW-1:0] xs, ys, xq, yq;
  logic signed [ZW-1:0] t;
  logic [15:0]          folded;
  logic                 fold_flip;
  coord_t               cos_c, sin_c;

  // quadrants two and three are rotated by a half turn and negated at the end
  assign fold_flip = angle[15] ^ angle[14];
  assign folded    = fold_flip ? (angle ^ 16'h8000) : angle;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign t  = ZW'(atan_entry(cnt));

  assign xq = x >>> 15;
  assign yq = y >>> 15;

  always_comb begin
    if (xq > 34'sd32767)       cos_c = 16'sd32767;
    else if (xq < -34'sd32767) cos_c = -16'sd32767;
    else                       cos_c = xq[15:0];
    if (yq > 34'sd32767)       sin_c = 16'sd32767;
    else if (yq < -34'sd32767) sin_c = -16'sd32767;
    else                       sin_c = yq[15:0];
  end

  assign cos_q15 = flip ? -cos_c : cos_c;
  assign sin_q15 = flip ? -sin_c : sin_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'(CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= {{(ZW-32){folded[15]}}, folded, 16'd0};
      flip <= fold_flip;
    end else if (run) begin
      if (!z[ZW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - t;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + t;
      end
    end
  end

endmodule

@@ rtl/ellipse_arc_vertex_generator.sv @@
// top level of the ellipse arc vertex generator: sequencer, shared multiplier, output register
// depends on eavg_pkg, eavg_divider, eavg_cordic and the assertion macro header
`include "ellipse_arc_vertex_generator_macros.svh"

// One request (pulse start while busy is low) expands into point_count + 2
// vertex beats: the center, point_count points on the ellipse, and the
// center again with last_vertex set. Each beat is on the result ports for
// exactly one cycle with strobe high; the receiver cannot stall, so it must
// take every beat as it comes. busy stays high from the cycle after start
// until the closing beat is shown, and a new request may be issued in that
// same cycle. Each arc point goes through these steps in order: launching
// the shared one-bit-a-cycle divider that spaces the angles, waiting while
// it works out 22 quotient bits and flags done, the rotation unit that makes
// sine and cosine in 16 micro-rotations, then the shared 17x17 multiplier
// for the x and y products and the final add. A point_count above
// MAX_POINTS is treated as MAX_POINTS. Coordinates wrap modulo 2^16.
module ellipse_arc_vertex_generator
  import eavg_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  coord_t      center_x,
  input  coord_t      center_y,
  input  logic [15:0] full_width,
  input  logic [15:0] full_height,
  input  logic [15:0] angle_begin,
  input  logic [15:0] angle_end,
  input  logic [5:0]  point_count,
  output logic        strobe,
  output coord_t      vertex_x,
  output coord_t      vertex_y,
  output logic        last_vertex
);

  localparam logic [5:0] MaxPts = 6'(MAX_POINTS);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_CENTER   = 9'b000000010,
    S_DIV_GO   = 9'b000000100,
    S_DIV_WAIT = 9'b000001000,
    S_COR_WAIT = 9'b000010000,
    S_MUL_X    = 9'b000100000,
    S_MUL_Y    = 9'b001000000,
    S_EMIT     = 9'b010000000,
    S_LAST     = 9'b100000000
  } state_t;

  state_t state, state_next;

  // request registers
  coord_t              cx, cy;
  logic [15:0]         w, h, begin_r;
  logic signed [16:0]  delta;
  logic [5:0]          n_sat;
  logic [5:0]          idx;
  // running delta * idx, fed to the divider
  logic signed [ACC_W-1:0] acc;
  // shared multiplier result and the x offset held while y is multiplied
  logic signed [32:0]  prod;
  coord_t              dx;

  logic                accept;
  logic                div_start, div_done;
  logic [15:0]         div_quot;
  logic                cor_start, cor_done;
  logic [15:0]         cor_angle;
  coord_t              cos_q15, sin_q15;
  logic signed [16:0]  mul_a, mul_b;
  logic [5:0]          n_in;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign n_in      = (point_count > MaxPts) ? MaxPts : point_count;
  assign div_start = (state == S_DIV_GO);
  assign cor_start = (state == S_DIV_WAIT) && div_done;
  // angle of point idx: begin + trunc(delta * idx / n), modulo a full turn
  assign cor_angle = begin_r + div_quot;

  // one multiplier, cos * width then sin * height
  assign mul_a = (state == S_MUL_X) ? 17'(cos_q15) : 17'(sin_q15);
  assign mul_b = (state == S_MUL_X) ? $signed({1'b0, w}) : $signed({1'b0, h});

  eavg_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (n_sat),
    .done     (div_done),
    .quotient (div_quot)
  );

  eavg_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_q15 (cos_q15),
    .sin_q15 (sin_q15)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (accept) state_next = S_CENTER;
      S_CENTER:   state_next = (n_sat == 6'd0) ? S_LAST : S_DIV_GO;
      S_DIV_GO:   state_next = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_next = S_COR_WAIT;
      S_COR_WAIT: if (cor_done) state_next = S_MUL_X;
      S_MUL_X:    state_next = S_MUL_Y;
      S_MUL_Y:    state_next = S_EMIT;
      S_EMIT:     state_next = (idx == n_sat - 6'd1) ? S_LAST : S_DIV_GO;
      S_LAST:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // control: state, strobe, point index
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      idx    <= '0;
    end else begin
      state  <= state_next;
      strobe <= (state == S_CENTER) || (state == S_EMIT) || (state == S_LAST);
      if (accept || state == S_LAST) begin
        idx <= '0;
      end else if (state == S_EMIT) begin
        idx <= idx + 6'd1;
      end
    end
  end

  // payload: request fields, datapath and output beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cx      <= center_x;
      cy      <= center_y;
      w       <= full_width;
      h       <= full_height;
      begin_r <= angle_begin;
      delta   <= $signed({1'b0, angle_end}) - $signed({1'b0, angle_begin});
      n_sat   <= n_in;
      acc     <= '0;
    end
    if (state == S_MUL_X) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_MUL_Y) begin
      dx   <= prod[31:16];
      prod <= mul_a * mul_b;
    end
    case (state)
      S_CENTER: begin
        vertex_x    <= cx;
        vertex_y    <= cy;
        last_vertex <= 1'b0;
      end
      S_EMIT: begin
        vertex_x    <= cx + dx;
        vertex_y    <= cy + prod[31:16];
        last_vertex <= 1'b0;
        acc         <= acc + {{(ACC_W-17){delta[16]}}, delta};
      end
      S_LAST: begin
        vertex_x    <= cx;
        vertex_y    <= cy;
        last_vertex <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  `EAVG_ASSERT_NXT(a_start_busy, accept, busy, "accepted request did not raise busy")
  `EAVG_ASSERT_IMP(a_last_idle, strobe && last_vertex, !busy, "closing beat while still busy")
  `EAVG_ASSERT_IMP(a_mid_busy, strobe && !last_vertex, busy, "open beat after run ended")
  `EAVG_ASSERT_IMP(a_idx_range, state == S_EMIT, idx < n_sat, "point index past count")
  `EAVG_ASSERT_IMP(a_div_owner, div_done, state == S_DIV_WAIT, "divider done out of turn")

endmodule

@@ tb/tb.sv @@
// self-checking testbench for ellipse_arc_vertex_generator: directed arcs, then random arcs
// depends on eavg_pkg and the generator rtl; holds its own cordic-based vertex predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eavg_pkg::*;

  localparam int ARC_POINT_LIMIT = MAX_POINTS_DEF;
  localparam int NUM_DIRECTED    = 21;
  localparam int RANDOM_ARCS     = 465;
  // random arcs in this index range go out back to back, no sender idling
  localparam int CALM_FIRST      = 200;
  localparam int CALM_LAST       = 290;
  localparam int IDLE_PERCENT    = 12;
  localparam int SETTLE_CYCLES   = 100;
  localparam longint ROT_GAIN_Q30 = 64'sd652032874;

  // one arc request as it sits on the input ports
  typedef struct packed {
    coord_t      cx;
    coord_t      cy;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] a0;
    logic [15:0] a1;
    logic [5:0]  npts;
  } arc_req_t;

  // directed row: center_only rows carry their expected beats implicitly
  // (center, then center flagged last), everything else goes to the predictor
  typedef struct packed {
    bit       center_only;
    arc_req_t arc;
  } arc_row_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } vertex_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  coord_t      center_x;
  coord_t      center_y;
  logic [15:0] full_width;
  logic [15:0] full_height;
  logic [15:0] angle_begin;
  logic [15:0] angle_end;
  logic [5:0]  point_count;
  logic        strobe;
  coord_t      vertex_x;
  coord_t      vertex_y;
  logic        last_vertex;

  vertex_t pending_vertices[$];
  int      mismatch_count;
  int      vertices_checked;
  int      arcs_sent;
  int      backward_arcs;
  int      clipped_arcs;
  int      empty_arcs;

  ellipse_arc_vertex_generator i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .center_x    (center_x),
    .center_y    (center_y),
    .full_width  (full_width),
    .full_height (full_height),
    .angle_begin (angle_begin),
    .angle_end   (angle_end),
    .point_count (point_count),
    .strobe      (strobe),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex)
  );

  // directed arcs: extremes, every fold boundary of the angle, backward sweeps,
  // point count saturation, coordinate wrap, zero sizes and zero span
  arc_row_t directed_arcs [NUM_DIRECTED] = '{
    // zero point count, only the two center beats
    '{1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd0}},
    '{1'b1, '{16'h7fff, 16'h8000, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 6'd0}},
    '{1'b1, '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 6'd0}},
    // single point at angle zero, full scale radii
    '{1'b0, '{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'h0000, 6'd1}},
    '{1'b0, '{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'hffff, 6'd4}},
    '{1'b0, '{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h4000, 16'hc000, 6'd16}},
    // backward sweeps, the last one with a truncating negative step
    '{1'b0, '{16'h00a0, 16'hff60, 16'd32000, 16'd16000, 16'hc000, 16'h4000, 6'd8}},
    '{1'b0, '{16'h0000, 16'h0000, 16'h1000, 16'h1000, 16'hffff, 16'h0000, 6'd3}},
    '{1'b0, '{16'h0064, 16'hff9c, 16'hffff, 16'hffff, 16'd100, 16'h0000, 6'd7}},
    // full point budget and a count above it
    '{1'b0, '{16'hfffb, 16'h0005, 16'd8000, 16'd12000, 16'h0000, 16'hffff, 6'd62}},
    '{1'b0, '{16'h0000, 16'h0000, 16'd8000, 16'd12000, 16'h0000, 16'hffff, 6'd63}},
    // coordinates wrapping past both ends
    '{1'b0, '{16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'h0000, 16'hffff, 6'd4}},
    '{1'b0, '{16'h8000, 16'h8000, 16'hffff, 16'hffff, 16'h8000, 16'h4000, 6'd4}},
    // flat ellipses and a zero span
    '{1'b0, '{16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'd1000, 16'd9000, 6'd5}},
    '{1'b0, '{16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'd1000, 16'd9000, 6'd5}},
    '{1'b0, '{16'd1234, 16'heef1, 16'd20000, 16'd30000, 16'd12345, 16'd12345, 6'd5}},
    // angle fold boundaries
    '{1'b0, '{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h3fff, 16'h4000, 6'd2}},
    '{1'b0, '{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hbfff, 16'hc000, 6'd2}},
    '{1'b0, '{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h7fff, 16'h8000, 6'd2}},
    // alternating bit patterns on every field
    '{1'b0, '{16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 6'd42}},
    '{1'b0, '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 6'd21}}
  };

  // arctangent of 2^-i, 2^32 units per turn
  function automatic longint atan_step(input int i);
    longint v;
    case (i)
      0:       v = 536870912;
      1:       v = 316933406;
      2:       v = 167458907;
      3:       v = 85004756;
      4:       v = 42667331;
      5:       v = 21354465;
      6:       v = 10679838;
      7:       v = 5340245;
      8:       v = 2670163;
      9:       v = 1335087;
      10:      v = 667544;
      11:      v = 333772;
      12:      v = 166886;
      13:      v = 83443;
      14:      v = 41721;
      default: v = 20860;
    endcase
    return v;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > 32767) return 32767;
    if (v < -32767) return -32767;
    return v;
  endfunction

  // q1.15 cosine and sine of a binary angle by a 16-step rotation
  function automatic void unit_circle_point(input logic [15:0] ang,
                                            output longint c, output longint s);
    longint a;
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    bit     flip;
    a    = longint'({48'd0, ang});
    flip = 1'b0;
    // fold into the right half plane
    if (a >= 16384 && a < 49152) begin
      a    = a - 32768;
      flip = 1'b1;
    end else if (a >= 49152) begin
      a = a - 65536;
    end
    z = a * 65536;
    x = ROT_GAIN_Q30;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step(i);
      end
    end
    c = clamp_unit(x >>> 15);
    s = clamp_unit(y >>> 15);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  // every beat one request makes: center, the arc points, center flagged last
  function automatic void predict_arc_vertices(input arc_req_t r);
    longint n;
    longint delta;
    longint step;
    longint c;
    longint s;
    longint cx;
    longint cy;
    vertex_t v;
    cx    = longint'(r.cx);
    cy    = longint'(r.cy);
    n     = (r.npts > ARC_POINT_LIMIT) ? ARC_POINT_LIMIT : longint'({58'd0, r.npts});
    delta = longint'({48'd0, r.a1}) - longint'({48'd0, r.a0});
    pending_vertices.push_back('{r.cx, r.cy, 1'b0});
    for (longint i = 0; i < n; i++) begin
      // signed division truncates toward zero, angle wraps mod one turn
      step = (delta * i) / n;
      unit_circle_point(16'(longint'({48'd0, r.a0}) + step), c, s);
      v.x    = 16'(cx + ((c * longint'({48'd0, r.w})) >>> 16));
      v.y    = 16'(cy + ((s * longint'({48'd0, r.h})) >>> 16));
      v.last = 1'b0;
      pending_vertices.push_back(v);
    end
    pending_vertices.push_back('{r.cx, r.cy, 1'b1});
  endfunction

  function automatic arc_req_t random_arc();
    arc_req_t r;
    int       pick;
    // mostly short arcs, a few long ones, keeps the run length sane
    pick = $urandom_range(99);
    if (pick < 70) r.npts = 6'($urandom_range(8));
    else if (pick < 92) r.npts = 6'($urandom_range(30, 9));
    else r.npts = 6'($urandom_range(63, 31));
    if ($urandom_range(3) == 0) begin
      r.cx = 16'($urandom_range(255)) - 16'd128;
      r.cy = 16'($urandom_range(255)) - 16'd128;
    end else begin
      r.cx = 16'($urandom);
      r.cy = 16'($urandom);
    end
    case ($urandom_range(9))
      0:       r.w = 16'h0000;
      1:       r.w = 16'hffff;
      default: r.w = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0:       r.h = 16'h0000;
      1:       r.h = 16'hffff;
      default: r.h = 16'($urandom);
    endcase
    r.a0 = 16'($urandom);
    case ($urandom_range(7))
      0:       r.a1 = r.a0;
      1:       r.a1 = r.a0 + 16'($urandom_range(64));
      2:       r.a1 = r.a0 - 16'($urandom_range(64));
      default: r.a1 = 16'($urandom);
    endcase
    return r;
  endfunction

  // present one request until it is taken; idle cycles put noise on the fields
  task automatic issue_arc(input arc_req_t r, input bit center_only, input bit calm);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
        start       <= 1'b0;
        center_x    <= 16'($urandom);
        center_y    <= 16'($urandom);
        full_width  <= 16'($urandom);
        full_height <= 16'($urandom);
        angle_begin <= 16'($urandom);
        angle_end   <= 16'($urandom);
        point_count <= 6'($urandom);
      end else begin
        start       <= 1'b1;
        center_x    <= r.cx;
        center_y    <= r.cy;
        full_width  <= r.w;
        full_height <= r.h;
        angle_begin <= r.a0;
        angle_end   <= r.a1;
        point_count <= r.npts;
      end
      @(posedge clk);
      taken = start && !busy;
    end
    if (center_only) begin
      pending_vertices.push_back('{r.cx, r.cy, 1'b0});
      pending_vertices.push_back('{r.cx, r.cy, 1'b1});
    end else begin
      predict_arc_vertices(r);
    end
    arcs_sent++;
    if (r.a1 < r.a0) backward_arcs++;
    if (r.npts > ARC_POINT_LIMIT) clipped_arcs++;
    if (r.npts == 0) empty_arcs++;
  endtask

  // hold off the sender until every expected beat has come out
  task automatic drain_vertices();
    start <= 1'b0;
    do @(posedge clk); while (pending_vertices.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: a beat is taken at the edge that ends its strobe cycle
  always @(posedge clk) begin
    vertex_t want;
    if (!rst && strobe) begin
      if (pending_vertices.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected vertex beat, expected none, actual x=%0d y=%0d last=%0b",
                 $time, vertex_x, vertex_y, last_vertex);
      end else begin
        want = pending_vertices.pop_front();
        vertices_checked++;
        if (vertex_x !== want.x || vertex_y !== want.y || last_vertex !== want.last) begin
          mismatch_count++;
          $display("%0t: vertex mismatch, expected x=%0d y=%0d last=%0b, actual x=%0d y=%0d last=%0b",
                   $time, want.x, want.y, want.last, vertex_x, vertex_y, last_vertex);
        end
      end
    end
  end

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    center_x    <= '0;
    center_y    <= '0;
    full_width  <= '0;
    full_height <= '0;
    angle_begin <= '0;
    angle_end   <= '0;
    point_count <= '0;
    mismatch_count   = 0;
    vertices_checked = 0;
    arcs_sent        = 0;
    backward_arcs    = 0;
    clipped_arcs     = 0;
    empty_arcs       = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int k = 0; k < NUM_DIRECTED; k++)
      issue_arc(directed_arcs[k].arc, directed_arcs[k].center_only, 1'b0);
    drain_vertices();

    // random arcs, with one back-to-back stretch and occasional full drains
    for (int k = 0; k < RANDOM_ARCS; k++) begin
      issue_arc(random_arc(), 1'b0, (k >= CALM_FIRST && k < CALM_LAST));
      if ((k < CALM_FIRST || k >= CALM_LAST) && $urandom_range(49) == 0)
        drain_vertices();
    end

    drain_vertices();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_vertices.size() != 0) begin
      mismatch_count++;
      $display("%0t: missing vertex beats, expected %0d more, actual none",
               $time, pending_vertices.size());
    end

    $display("covered %0d arc requests: %0d swept backward, %0d above the point limit, %0d empty",
             arcs_sent, backward_arcs, clipped_arcs, empty_arcs);
    $display("%0d vertex beats compared, sender idling random apart from one back-to-back run",
             vertices_checked);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // guard against a hung handshake; far above the slowest correct run
  initial begin
    #60ms;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/eavg_pkg.sv
rtl/eavg_divider.sv
rtl/eavg_cordic.sv
rtl/ellipse_arc_vertex_generator.sv
tb/tb.sv
